FILE: rtl/dtd_pkg.sv
`default_nettype none
package dtd_pkg;

  localparam int unsigned CH_BITS    = 2;
  localparam int unsigned RAW_BITS   = 32;
  localparam int unsigned VAL_BITS   = 26;
  localparam int unsigned CNT_BITS   = 32;
  localparam int unsigned PER_BITS   = 16;
  localparam int unsigned NUM_STAT   = 5;
  localparam int unsigned DIV_STEPS  = VAL_BITS;
  localparam int unsigned STEP_BITS  = $clog2(DIV_STEPS);
  localparam int unsigned IN_BITS    = 40;
  localparam int unsigned OUT_BITS   = 72;

  // eRPM numerator: microseconds per minute
  localparam logic [VAL_BITS-1:0] ERPM_NUM    = 26'd60000000;
  localparam logic [PER_BITS-1:0] PERIOD_STOP = 16'hff80;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_TIMEOUT   = 3'd1,
    STAT_BAD_CODE  = 3'd2,
    STAT_BAD_CHECK = 3'd3,
    STAT_BAD_KIND  = 3'd4
  } dtd_status_e;

  typedef enum logic [1:0] {
    KIND_ERPM    = 2'd0,
    KIND_TEMP    = 2'd1,
    KIND_VOLTAGE = 2'd2,
    KIND_CURRENT = 2'd3
  } dtd_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } dtd_state_e;

  // classified request handed from the front end to the back end
  typedef struct packed {
    logic [CH_BITS-1:0]  channel;
    dtd_status_e         status;
    dtd_kind_e           kind;
    logic [VAL_BITS-1:0] value;
    logic                need_div;
    logic [PER_BITS-1:0] period;
  } dtd_item_t;

  // GCR 5b -> 4b; bit 4 set when the code is valid
  function automatic logic [4:0] gcr_decode(input logic [4:0] code);
    logic [4:0] res;
    case (code)
      5'h09: res = 5'h19;
      5'h0a: res = 5'h1a;
      5'h0b: res = 5'h1b;
      5'h0d: res = 5'h1d;
      5'h0e: res = 5'h1e;
      5'h0f: res = 5'h1f;
      5'h12: res = 5'h12;
      5'h13: res = 5'h13;
      5'h15: res = 5'h15;
      5'h16: res = 5'h16;
      5'h17: res = 5'h17;
      5'h19: res = 5'h10;
      5'h1a: res = 5'h18;
      5'h1b: res = 5'h11;
      5'h1d: res = 5'h14;
      5'h1e: res = 5'h1c;
      default: res = 5'h00;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/dtd_front.sv
`default_nettype none
module dtd_front import dtd_pkg::*; (
  input  wire logic                s_axis_tvalid_i,
  input  wire logic [IN_BITS-1:0]  s_axis_tdata_i,
  output logic                     s_axis_tready_o,
  input  wire logic                full_i,
  output logic                     push_o,
  output dtd_item_t                item_o
);

  logic [CH_BITS-1:0]  channel;
  logic [RAW_BITS-1:0] raw;
  logic [19:0]         tw;
  logic [4:0]          d3, d2, d1, d0;
  logic [15:0]         frame;
  logic                code_ok;
  logic                crc_ok;
  logic [3:0]          ftype;
  logic [2:0]          expo;
  logic [8:0]          mant;
  logic [PER_BITS-1:0] period;

  assign channel = s_axis_tdata_i[CH_BITS-1:0];
  assign raw     = s_axis_tdata_i[CH_BITS +: RAW_BITS];

  // transitions of the sampled line; only the low 20 bits carry the frame
  assign tw = raw[19:0] ^ raw[20:1];
  assign d3 = gcr_decode(tw[19:15]);
  assign d2 = gcr_decode(tw[14:10]);
  assign d1 = gcr_decode(tw[9:5]);
  assign d0 = gcr_decode(tw[4:0]);

  assign code_ok = d3[4] & d2[4] & d1[4] & d0[4];
  assign frame   = {d3[3:0], d2[3:0], d1[3:0], d0[3:0]};
  assign crc_ok  = ~(frame[7:4] ^ frame[11:8] ^ frame[15:12]) == frame[3:0];
  assign ftype   = frame[15:12];
  assign expo    = frame[15:13];
  assign mant    = frame[12:4];
  assign period  = PER_BITS'({7'd0, mant} << expo);

  always_comb begin
    item_o          = '0;
    item_o.channel  = channel;
    item_o.status   = STAT_OK;
    item_o.kind     = KIND_ERPM;
    if (raw == '0) begin
      item_o.status = STAT_TIMEOUT;
    end else if (!code_ok) begin
      item_o.status = STAT_BAD_CODE;
    end else if (!crc_ok) begin
      item_o.status = STAT_BAD_CHECK;
    end else if (ftype[3] && !ftype[0]) begin
      item_o.status = STAT_BAD_KIND;
    end else if (ftype == 4'h2) begin
      item_o.kind  = KIND_TEMP;
      item_o.value = VAL_BITS'(mant);
    end else if (ftype == 4'h4) begin
      item_o.kind  = KIND_VOLTAGE;
      item_o.value = VAL_BITS'(mant[8:2]);
    end else if (ftype == 4'h6) begin
      item_o.kind  = KIND_CURRENT;
      item_o.value = VAL_BITS'(mant);
    end else begin
      item_o.period   = period;
      item_o.need_div = (period != '0) && (period != PERIOD_STOP);
    end
  end

  assign s_axis_tready_o = !full_i;
  assign push_o          = s_axis_tvalid_i && !full_i;

endmodule
`default_nettype wire

FILE: rtl/dtd_fifo.sv
`default_nettype none
module dtd_fifo import dtd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire dtd_item_t item_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           avail_o,
  output dtd_item_t      item_o
);

  dtd_item_t  mem_q [0:1];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;

  assign full_o  = fill_q == 2'd2;
  assign avail_o = fill_q != 2'd0;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    fill_d   = fill_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/dtd_back.sv
`default_nettype none
module dtd_back import dtd_pkg::*; #(
  parameter int unsigned CHANNELS = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                avail_i,
  input  wire dtd_item_t           item_i,
  output logic                     pop_o,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [OUT_BITS-1:0]      m_axis_tdata_o
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  dtd_state_e          state_q, state_d;
  dtd_item_t           item_q;
  logic [VAL_BITS-1:0] div_q, div_d;
  logic [PER_BITS:0]   rem_q, rem_d;
  logic [STEP_BITS-1:0] step_q, step_d;
  logic [CNT_BITS-1:0] counts_q [0:NUM_STAT-1][0:CHANNELS-1];
  logic                out_vld_q, out_vld_d;
  logic [OUT_BITS-1:0] out_q;
  logic                load;
  logic [PER_BITS:0]   rem_sh;
  logic                ge;
  logic [4:0]          ch_ext;
  logic                ch_ok;
  logic [CH_W-1:0]     ch_idx;
  logic [CNT_BITS-1:0] cnt_inc;
  logic [CNT_BITS-1:0] cnt_out;
  logic [VAL_BITS-1:0] value;

  // one restoring division step per cycle
  assign rem_sh = {rem_q[PER_BITS-1:0], div_q[VAL_BITS-1]};
  assign ge     = rem_sh >= {1'b0, item_q.period};

  assign ch_ext  = {3'd0, item_q.channel};
  assign ch_ok   = ch_ext < 5'(CHANNELS);
  assign ch_idx  = ch_ext[CH_W-1:0];
  assign cnt_inc = counts_q[item_q.status][ch_idx] + 1'b1;
  assign cnt_out = ch_ok ? cnt_inc : '0;
  assign value   = item_q.need_div ? div_q : item_q.value;

  always_comb begin
    state_d   = state_q;
    div_d     = div_q;
    rem_d     = rem_q;
    step_d    = step_q;
    pop_o     = 1'b0;
    load      = 1'b0;
    out_vld_d = out_vld_q && !m_axis_tready_i;
    case (state_q)
      BK_IDLE: begin
        if (avail_i) begin
          pop_o   = 1'b1;
          div_d   = ERPM_NUM;
          rem_d   = '0;
          step_d  = '0;
          state_d = item_i.need_div ? BK_DIV : BK_DONE;
        end
      end
      BK_DIV: begin
        rem_d  = ge ? (rem_sh - {1'b0, item_q.period}) : rem_sh;
        div_d  = {div_q[VAL_BITS-2:0], ge};
        step_d = step_q + 1'b1;
        if (step_q == STEP_BITS'(DIV_STEPS - 1)) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          load      = 1'b1;
          out_vld_d = 1'b1;
          state_d   = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q  <= div_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    if (pop_o) begin
      item_q <= item_i;
    end
    if (load) begin
      out_q <= {7'd0, cnt_out, value, item_q.kind, item_q.status, item_q.channel};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_STAT; s++) begin
        for (int c = 0; c < CHANNELS; c++) begin
          counts_q[s][c] <= '0;
        end
      end
    end else if (load && ch_ok) begin
      counts_q[item_q.status][ch_idx] <= cnt_inc;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

endmodule
`default_nettype wire

FILE: rtl/dshot_telemetry_decoder_top.sv
// Path: a request is decoded as it is accepted and written into the queue; the back end
//   pops it, runs an eRPM reply that needs it through the divide and registers the result.
// Flow: the back end works on one request at a time and pops the next only after the last
//   result is loaded; the 26-step radix-2 divider in the back end handles the eRPM divide.
// Reset: rst_ni asynchronous, active low; clears the queue, back-end state and
//   all per-channel event counters at once.
`default_nettype none
module dshot_telemetry_decoder_top import dtd_pkg::*; #(
  parameter int unsigned CHANNELS = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request: [1:0] channel, [33:2] raw_word, [39:34] zero
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [IN_BITS-1:0]  s_axis_tdata_i,
  // result: [1:0] channel_out, [4:2] status, [6:5] telemetry_kind,
  //         [32:7] telemetry_value, [64:33] event_count, [71:65] zero
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [OUT_BITS-1:0]      m_axis_tdata_o
);

  // Front end: GCR decode, CRC check and type classification, all in
  // the accept cycle; the classified request goes straight into the queue.
  dtd_item_t push_item;
  dtd_item_t pop_item;
  logic      push;
  logic      pop;
  logic      full;
  logic      avail;

  dtd_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tready_o (s_axis_tready_o),
    .full_i          (full),
    .push_o          (push),
    .item_o          (push_item)
  );

  // Two-entry queue so the front end keeps taking requests while the
  // back end divides or waits on a stalled output.
  dtd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .item_o  (pop_item)
  );

  // Back end: eRPM divide, counter bump and the registered result stage.
  dtd_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .avail_i         (avail),
    .item_i          (pop_item),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule
`default_nettype wire

FILE: rtl/dtd_checker.sv
`default_nettype none
module dtd_checker import dtd_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                m_axis_tvalid_o,
  input wire logic                m_axis_tready_i,
  input wire logic [OUT_BITS-1:0] m_axis_tdata_o
);

  logic [2:0]          st;
  logic [1:0]          kd;
  logic [VAL_BITS-1:0] val;

  assign st  = m_axis_tdata_o[4:2];
  assign kd  = m_axis_tdata_o[6:5];
  assign val = m_axis_tdata_o[32:7];

  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> st <= STAT_BAD_KIND)
    else $error("status out of range");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && st != STAT_OK |-> kd == KIND_ERPM && val == '0)
    else $error("error result carries telemetry");

  a_small_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && st == STAT_OK && kd != KIND_ERPM |-> val < 26'd512)
    else $error("telemetry value too wide");

  a_erpm_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && st == STAT_OK |-> val <= ERPM_NUM)
    else $error("eRPM above limit");

endmodule

bind dshot_telemetry_decoder_top dtd_checker u_dtd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire

FILE: verif/testbench.sv
module testbench import dtd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CHAN_COUNT   = 4;
  localparam int unsigned RANDOM_ITEMS = 2000;
  // the closing stretch of requests runs with no idling on either side
  localparam int unsigned QUIET_TAIL   = 200;

  // one captured reply word as it waits to be sent
  typedef struct packed {
    logic [RAW_BITS-1:0] raw;
    logic [CH_BITS-1:0]  channel;
  } reply_req_t;

  // one decoded telemetry result as the block should report it
  typedef struct {
    logic [CH_BITS-1:0]  channel;
    dtd_status_e         status;
    dtd_kind_e           kind;
    logic [VAL_BITS-1:0] value;
    logic [CNT_BITS-1:0] count;
  } telemetry_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [IN_BITS-1:0]  s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OUT_BITS-1:0] m_axis_tdata_o;

  reply_req_t pending_replies[$];
  telemetry_t awaited_telemetry[$];

  // per-channel event counters, one column per status code
  logic [CNT_BITS-1:0] event_tally [CHAN_COUNT][NUM_STAT];

  int unsigned mismatch_count = 0;
  logic        req_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned ready_gap = 0;

  dshot_telemetry_decoder_top #(
    .CHANNELS(CHAN_COUNT)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // 4b nibble -> 5b GCR symbol
  function automatic logic [4:0] gcr_symbol(input logic [3:0] nibble);
    case (nibble)
      4'h0: return 5'h19;
      4'h1: return 5'h1b;
      4'h2: return 5'h12;
      4'h3: return 5'h13;
      4'h4: return 5'h1d;
      4'h5: return 5'h15;
      4'h6: return 5'h16;
      4'h7: return 5'h17;
      4'h8: return 5'h1a;
      4'h9: return 5'h09;
      4'ha: return 5'h0a;
      4'hb: return 5'h0b;
      4'hc: return 5'h1e;
      4'hd: return 5'h0d;
      4'he: return 5'h0e;
      default: return 5'h0f;
    endcase
  endfunction

  // Invert the symbol map by search; bit 4 of the result flags a legal symbol.
  function automatic logic [4:0] gcr_nibble(input logic [4:0] symbol);
    for (int n = 0; n < 16; n++) begin
      if (gcr_symbol(4'(n)) == symbol) return {1'b1, 4'(n)};
    end
    return 5'h00;
  endfunction

  // Decode one reply word and advance the channel counter it hits.
  function automatic telemetry_t decode_telemetry(input logic [CH_BITS-1:0] channel,
                                                  input logic [RAW_BITS-1:0] raw);
    telemetry_t          res;
    logic [31:0]         edges;
    logic [15:0]         frame;
    logic [4:0]          sym;
    logic                code_ok;
    logic [3:0]          kind_nib;
    logic [2:0]          expo;
    logic [8:0]          mant;
    logic [31:0]         period;
    res.channel = channel;
    res.status  = STAT_OK;
    res.kind    = KIND_ERPM;
    res.value   = '0;
    res.count   = '0;
    if (raw == '0) begin
      res.status = STAT_TIMEOUT;
    end else begin
      // transitions of the line; only the low four symbols carry the frame
      edges   = raw ^ (raw >> 1);
      frame   = '0;
      code_ok = 1'b1;
      for (int g = 0; g < 4; g++) begin
        sym = gcr_nibble(edges[5*g +: 5]);
        if (!sym[4]) code_ok = 1'b0;
        frame[4*g +: 4] = sym[3:0];
      end
      kind_nib = frame[15:12];
      expo     = frame[15:13];
      mant     = frame[12:4];
      if (!code_ok) begin
        res.status = STAT_BAD_CODE;
      end else if (~(frame[15:12] ^ frame[11:8] ^ frame[7:4]) != frame[3:0]) begin
        res.status = STAT_BAD_CHECK;
      end else if (kind_nib[3] && !kind_nib[0]) begin
        // even type nibbles from 8 upward are rejected
        res.status = STAT_BAD_KIND;
      end else if (kind_nib == 4'h2) begin
        res.kind  = KIND_TEMP;
        res.value = VAL_BITS'(mant);
      end else if (kind_nib == 4'h4) begin
        res.kind  = KIND_VOLTAGE;
        res.value = VAL_BITS'(mant >> 2);
      end else if (kind_nib == 4'h6) begin
        res.kind  = KIND_CURRENT;
        res.value = VAL_BITS'(mant);
      end else begin
        period = 32'(mant) << expo;
        if (period != 0 && period != 32'hff80) res.value = VAL_BITS'(32'd60000000 / period);
      end
    end
    if (channel < CHAN_COUNT) begin
      event_tally[channel][res.status] = event_tally[channel][res.status] + 1'b1;
      res.count = event_tally[channel][res.status];
    end
    return res;
  endfunction

  // Append the check nibble to a 12-bit frame body.
  function automatic logic [15:0] sealed_frame(input logic [11:0] body);
    return {body, ~(body[11:8] ^ body[7:4] ^ body[3:0])};
  endfunction

  // Turn a transition word back into line samples, top bit first.
  function automatic logic [31:0] line_word(input logic [31:0] edges);
    logic [31:0] raw;
    raw[31] = edges[31];
    for (int i = 30; i >= 0; i--) raw[i] = edges[i] ^ raw[i+1];
    return raw;
  endfunction

  // Build a reply word from a frame; a symbol index 0..3 spoils that symbol.
  function automatic logic [31:0] reply_word(input logic [15:0] frame,
                                             input int spoil_group);
    logic [31:0] edges;
    logic [4:0]  bad_sym;
    logic [4:0]  probe;
    edges = {12'($urandom), 20'h0};
    for (int g = 0; g < 4; g++) edges[5*g +: 5] = gcr_symbol(frame[4*g +: 4]);
    if (spoil_group >= 0) begin
      do begin
        bad_sym = 5'($urandom_range(0, 31));
        probe   = gcr_nibble(bad_sym);
      end while (probe[4]);
      edges[5*spoil_group +: 5] = bad_sym;
    end
    return line_word(edges);
  endfunction

  task automatic queue_reply(input logic [CH_BITS-1:0] channel, input logic [31:0] raw);
    reply_req_t req;
    req.channel = channel;
    req.raw     = raw;
    pending_replies.push_back(req);
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    $display("%0t mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // Sender: present a new request once the last one has gone, with idle bursts.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || req_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_replies.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        // start an idle burst
        send_gap = $urandom_range(0, 15);
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_replies.size() > 0) begin
        s_axis_tdata_i  <= IN_BITS'(pending_replies.pop_front());
        s_axis_tvalid_i <= 1'b1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall in bursts until the closing stretch, then stay ready.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (ready_gap > 0) begin
        ready_gap--;
        m_axis_tready_i <= 1'b0;
      end else if (pending_replies.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        ready_gap = $urandom_range(0, 15);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Monitor: predict on each accepted request, check each accepted result.
  always @(posedge clk_i) begin
    telemetry_t want;
    req_taken = s_axis_tvalid_i && s_axis_tready_o;
    if (req_taken)
      awaited_telemetry.push_back(decode_telemetry(s_axis_tdata_i[1:0], s_axis_tdata_i[33:2]));
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (awaited_telemetry.size() == 0) begin
        note_mismatch("result with none outstanding", m_axis_tdata_o[31:0], 32'h0);
      end else begin
        want = awaited_telemetry.pop_front();
        if (m_axis_tdata_o[1:0] != want.channel)
          note_mismatch("channel_out", 32'(m_axis_tdata_o[1:0]), 32'(want.channel));
        if (m_axis_tdata_o[4:2] != want.status)
          note_mismatch("status", 32'(m_axis_tdata_o[4:2]), 32'(want.status));
        if (m_axis_tdata_o[6:5] != want.kind)
          note_mismatch("telemetry_kind", 32'(m_axis_tdata_o[6:5]), 32'(want.kind));
        if (m_axis_tdata_o[32:7] != want.value)
          note_mismatch("telemetry_value", 32'(m_axis_tdata_o[32:7]), 32'(want.value));
        if (m_axis_tdata_o[64:33] != want.count)
          note_mismatch("event_count", m_axis_tdata_o[64:33], want.count);
      end
    end
  end

  initial begin
    int unsigned       pick;
    logic [11:0]       body;
    logic [15:0]       frame;
    logic [3:0]        odd_kinds [7];
    odd_kinds = '{4'h1, 4'h3, 4'h5, 4'h7, 4'h9, 4'hb, 4'hd};
    for (int c = 0; c < CHAN_COUNT; c++)
      for (int s = 0; s < NUM_STAT; s++) event_tally[c][s] = '0;

    // Directed: timeout, every type nibble, the eRPM period extremes,
    // broken check nibble and a broken symbol in each position.
    queue_reply(2'd0, 32'h0);
    queue_reply(2'd3, 32'hffff_ffff);
    queue_reply(2'd1, reply_word(sealed_frame(12'hfff), -1));   // stop period
    queue_reply(2'd2, reply_word(sealed_frame(12'h000), -1));   // zero period
    queue_reply(2'd3, reply_word(sealed_frame(12'h001), -1));   // shortest period
    queue_reply(2'd0, reply_word(sealed_frame(12'hffe), -1));   // longest live period
    queue_reply(2'd1, reply_word(sealed_frame(12'h2ff), -1));   // temperature
    queue_reply(2'd2, reply_word(sealed_frame(12'h4ff), -1));   // voltage
    queue_reply(2'd3, reply_word(sealed_frame(12'h403), -1));   // voltage rounds to zero
    queue_reply(2'd0, reply_word(sealed_frame(12'h6ff), -1));   // current
    queue_reply(2'd1, reply_word(sealed_frame(12'h8ab), -1));
    queue_reply(2'd2, reply_word(sealed_frame(12'ha00), -1));
    queue_reply(2'd3, reply_word(sealed_frame(12'hcff), -1));
    queue_reply(2'd0, reply_word(sealed_frame(12'he55), -1));
    foreach (odd_kinds[k])
      queue_reply(2'(k), reply_word(sealed_frame({odd_kinds[k], 8'($urandom)}), -1));
    queue_reply(2'd1, reply_word(sealed_frame(12'h123) ^ 16'h0001, -1));
    for (int g = 0; g < 4; g++)
      queue_reply(2'(g), reply_word(sealed_frame(12'($urandom)), g));

    // Random: mostly sound frames with random content, the rest broken or noise.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick  = $urandom_range(0, 99);
      body  = 12'($urandom);
      frame = sealed_frame(body);
      if (pick < 70)
        queue_reply(2'($urandom), reply_word(frame, -1));
      else if (pick < 80)
        queue_reply(2'($urandom), reply_word(frame ^ 16'($urandom_range(1, 15)), -1));
      else if (pick < 90)
        queue_reply(2'($urandom), reply_word(frame, $urandom_range(0, 3)));
      else if (pick < 95)
        queue_reply(2'($urandom), 32'h0);
      else
        queue_reply(2'($urandom), $urandom);
    end

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // drain: every request sent, every result back, then a short settle
    while (pending_replies.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (awaited_telemetry.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
